### design/cpg_pkg.sv
// cpg_pkg: shared types and constants for the circle pixel generator
// depends on nothing; used by cpg_front, cpg_queue, cpg_back and circle_pixel_generator
package cpg_pkg;

    // action codes of an input transaction
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    // entries in the queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    // top bit of the page mask
    localparam logic [7:0] MASK_TOP = 8'h80;

    // default display size
    localparam int unsigned DEF_WIDTH  = 128;
    localparam int unsigned DEF_HEIGHT = 64;

    // one iteration as handed from front to back: centre, cursor before
    // the update (low byte only, points are taken modulo 256), done flag
    typedef struct packed {
        logic [7:0] cx;
        logic [7:0] cy;
        logic [7:0] xx;
        logic [7:0] yy;
        logic       done;
    } t_iter;

endpackage

### design/cpg_if.sv
// cpg_in_if / cpg_out_if: valid-ready channels of the circle pixel generator
// no dependencies
interface cpg_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] center_x;
    logic [7:0] center_y;
    logic [6:0] radius;

    modport source (output valid, output action, output center_x, output center_y,
                    output radius, input ready);
    modport sink   (input valid, input action, input center_x, input center_y,
                    input radius, output ready);
endinterface

interface cpg_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] pixel_column;
    logic [5:0] pixel_row;
    logic [2:0] page_index;
    logic [7:0] bit_mask;
    logic       last_of_step;
    logic       circle_done;

    modport source (output valid, output pixel_column, output pixel_row,
                    output page_index, output bit_mask, output last_of_step,
                    output circle_done, input ready);
    modport sink   (input valid, input pixel_column, input pixel_row,
                    input page_index, input bit_mask, input last_of_step,
                    input circle_done, output ready);
endinterface

### design/cpg_front.sv
// cpg_front: accepts start/step transactions, runs the error-term update
// depends on cpg_pkg and cpg_in_if
module cpg_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    cpg_in_if.sink          i_in,
    input  logic            i_push_ready,
    output logic            o_push_valid,
    output cpg_pkg::t_iter  o_push_data
);

    logic [8:0]  r_xx, n_xx;
    logic [8:0]  r_yy, n_yy;
    logic [11:0] r_e,  n_e;
    logic [7:0]  r_cx, n_cx;
    logic [7:0]  r_cy, n_cy;
    logic        r_active, n_active;

    logic        is_start;
    logic        accept;
    logic [8:0]  cur_xx, cur_yy, xx1, yy1;
    logic [11:0] cur_e, e1, e2;
    logic        done;

    assign i_in.ready = i_push_ready;
    assign accept     = i_in.valid && i_in.ready;
    assign is_start   = (i_in.action == cpg_pkg::ACT_START);

    // state seen by this iteration: freshly loaded on start
    always_comb begin
        if (is_start) begin
            cur_xx = 9'd0 - {2'b00, i_in.radius};
            cur_yy = 9'd0;
            cur_e  = 12'd2 - {4'b0000, i_in.radius, 1'b0};
        end else begin
            cur_xx = r_xx;
            cur_yy = r_yy;
            cur_e  = r_e;
        end
    end

    // error-term step, x first then y
    always_comb begin
        xx1 = cur_xx;
        e1  = cur_e;
        if ($signed(cur_e) > $signed({{3{cur_xx[8]}}, cur_xx})) begin
            xx1 = cur_xx + 9'd1;
            e1  = cur_e + {{2{xx1[8]}}, xx1, 1'b0} + 12'd1;
        end
        yy1 = cur_yy;
        e2  = e1;
        if ($signed(e1) <= $signed({{3{cur_yy[8]}}, cur_yy})) begin
            yy1 = cur_yy + 9'd1;
            e2  = e1 + {{2{yy1[8]}}, yy1, 1'b0} + 12'd1;
        end
        done = !xx1[8];
    end

    // iteration record for the back end; idle steps are dropped
    assign o_push_valid     = i_in.valid && (is_start || r_active);
    assign o_push_data.cx   = is_start ? i_in.center_x : r_cx;
    assign o_push_data.cy   = is_start ? i_in.center_y : r_cy;
    assign o_push_data.xx   = cur_xx[7:0];
    assign o_push_data.yy   = cur_yy[7:0];
    assign o_push_data.done = done;

    // next state
    always_comb begin
        n_xx     = r_xx;
        n_yy     = r_yy;
        n_e      = r_e;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_active = r_active;
        if (accept && (is_start || r_active)) begin
            n_xx     = xx1;
            n_yy     = yy1;
            n_e      = e2;
            n_cx     = o_push_data.cx;
            n_cy     = o_push_data.cy;
            n_active = !done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xx     <= '0;
            r_yy     <= '0;
            r_e      <= '0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_active <= 1'b0;
        end else begin
            r_xx     <= n_xx;
            r_yy     <= n_yy;
            r_e      <= n_e;
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_active <= n_active;
        end
    end

    // a finishing iteration leaves no circle active
    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push_valid && i_push_ready && o_push_data.done) |=> !r_active)
        else $error("circle still active after finishing iteration");

endmodule

### design/cpg_queue.sv
// cpg_queue: short register queue of iteration records, front to back
// depends on cpg_pkg
module cpg_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    input  cpg_pkg::t_iter  i_push_data,
    output logic            o_push_ready,
    output logic            o_pop_valid,
    output cpg_pkg::t_iter  o_pop_data,
    input  logic            i_pop
);

    localparam int unsigned Depth = cpg_pkg::QUEUE_DEPTH;
    localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW  = $clog2(Depth + 1);

    cpg_pkg::t_iter r_mem [Depth];
    logic [PtrW-1:0] r_wptr, r_rptr;
    logic [CntW-1:0] r_cnt;
    logic            push, pop;

    assign o_push_ready = (r_cnt != CntW'(Depth));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    // storage write
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == PtrW'(Depth - 1)) ? '0 : r_wptr + PtrW'(1);
            end
            if (pop) begin
                r_rptr <= (r_rptr == PtrW'(Depth - 1)) ? '0 : r_rptr + PtrW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CntW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CntW'(1);
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(Depth))
        else $error("queue fill count beyond depth");

endmodule

### design/cpg_back.sv
// cpg_back: expands one iteration record into four clamped display points
// depends on cpg_pkg and cpg_out_if
module cpg_back #(
    parameter int unsigned WIDTH  = cpg_pkg::DEF_WIDTH,
    parameter int unsigned HEIGHT = cpg_pkg::DEF_HEIGHT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_pop_valid,
    input  cpg_pkg::t_iter  i_pop_data,
    output logic            o_pop,
    cpg_out_if.source       o_out
);

    localparam logic [7:0] ColMax = 8'(WIDTH - 1);
    localparam logic [7:0] RowMax = 8'(HEIGHT - 1);

    // point order within an iteration
    localparam logic [1:0] PT_A = 2'd0;
    localparam logic [1:0] PT_B = 2'd1;
    localparam logic [1:0] PT_C = 2'd2;
    localparam logic [1:0] PT_D = 2'd3;

    cpg_pkg::t_iter r_rec;
    logic           r_busy;
    logic [1:0]     r_idx;
    logic           r_valid;
    logic [6:0]     r_col;
    logic [5:0]     r_row;
    logic [2:0]     r_page;
    logic [7:0]     r_mask;
    logic           r_last;
    logic           r_done;

    logic       advance;
    logic       load;
    logic [7:0] px, py, col, row;

    assign advance = r_busy && (!r_valid || o_out.ready);
    assign load    = i_pop_valid && (!r_busy || (advance && r_idx == PT_D));
    assign o_pop   = load;

    // quadrant point for the current index, modulo 256
    always_comb begin
        case (r_idx)
            PT_A: begin
                px = r_rec.cx - r_rec.xx;
                py = r_rec.cy + r_rec.yy;
            end
            PT_B: begin
                px = r_rec.cx - r_rec.yy;
                py = r_rec.cy - r_rec.xx;
            end
            PT_C: begin
                px = r_rec.cx + r_rec.xx;
                py = r_rec.cy - r_rec.yy;
            end
            PT_D: begin
                px = r_rec.cx + r_rec.yy;
                py = r_rec.cy + r_rec.xx;
            end
            default: begin
                px = r_rec.cx;
                py = r_rec.cy;
            end
        endcase
        col = (px > ColMax) ? ColMax : px;
        row = (py > RowMax) ? RowMax : py;
    end

    // point sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= PT_A;
        end else begin
            if (advance) begin
                r_idx <= r_idx + 2'd1;
            end
            if (load) begin
                r_busy <= 1'b1;
            end else if (advance && r_idx == PT_D) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rec <= i_pop_data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_col  <= col[6:0];
            r_row  <= row[5:0];
            r_page <= row[5:3];
            r_mask <= cpg_pkg::MASK_TOP >> row[2:0];
            r_last <= (r_idx == PT_D);
            r_done <= r_rec.done;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.pixel_column = r_col;
    assign o_out.pixel_row    = r_row;
    assign o_out.page_index   = r_page;
    assign o_out.bit_mask     = r_mask;
    assign o_out.last_of_step = r_last;
    assign o_out.circle_done  = r_done;

    a_idle_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_idx == PT_A))
        else $error("point index not at start while idle");

    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (!r_busy || (advance && r_idx == PT_D)))
        else $error("record taken while iteration in progress");

endmodule

### design/circle_pixel_generator.sv
// circle_pixel_generator: midpoint circle rasterizer for a paged display
// depends on cpg_pkg, cpg_if, cpg_front, cpg_queue and cpg_back
//
// usage:
//   i_in carries one transaction per iteration: action start (with centre
//   and radius) or step. Each start, and each step while a circle is
//   active, yields four point transactions on o_out in quadrant order;
//   the fourth has last_of_step set, and circle_done is set on all four
//   points of the iteration that finishes the circle. A step with no
//   circle active is accepted and produces nothing.
//   With the back end idle and the queue empty, the first point of an
//   iteration passes the queue, the back end's record register and its
//   output register; else it waits behind the points still queued ahead
//   of it. throughput: one point per cycle while o_out.ready is high,
//   set by the single point sequencer in the back end; the front takes a
//   transaction every cycle while the 2-entry record queue has room.
//   reset: i_rst_n (synchronous, active low) clears the cursor, the
//   error term, the active flag, the queue and the output register.
//   stall: while o_out.ready is low the current point holds, the queue
//   fills, and i_in.ready drops once it is full.
module circle_pixel_generator #(
    parameter int unsigned WIDTH  = cpg_pkg::DEF_WIDTH,
    parameter int unsigned HEIGHT = cpg_pkg::DEF_HEIGHT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cpg_in_if.sink     i_in,
    cpg_out_if.source  o_out
);

    logic           push_valid, push_ready;
    cpg_pkg::t_iter push_data;
    logic           pop_valid, pop;
    cpg_pkg::t_iter pop_data;

    // error-term front end
    cpg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_push_ready (push_ready),
        .o_push_valid (push_valid),
        .o_push_data  (push_data)
    );

    // iteration queue
    cpg_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_data  (push_data),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_data   (pop_data),
        .i_pop        (pop)
    );

    // point back end
    cpg_back #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_data  (pop_data),
        .o_pop       (pop),
        .o_out       (o_out)
    );

endmodule

### dv/circle_pixel_generator_tb.sv
// circle_pixel_generator_tb: self-checking bench for the midpoint circle rasterizer
// depends on cpg_pkg, cpg_if and circle_pixel_generator; drives start/step transactions,
// predicts the four quadrant points of each iteration and checks every point transaction
module circle_pixel_generator_tb;

    localparam int RANDOM_ITEMS = 105;
    localparam int HOLD_CYCLES  = 80;
    localparam int MAX_REPORTS  = 10;

    // one plotted point as seen on the output channel
    typedef struct packed {
        logic [6:0] column;
        logic [5:0] row;
        logic [2:0] page;
        logic [7:0] mask;
        logic       last;
        logic       done;
    } t_pixel;

    // how a directed row is checked
    typedef enum logic [1:0] {
        BY_MODEL,
        NO_POINTS,
        CENTRE_X4
    } t_row_check;

    typedef struct packed {
        logic       act;
        logic [7:0] x;
        logic [7:0] y;
        logic [6:0] rad;
        t_row_check chk;
        logic [6:0] column;
        logic [5:0] row;
        logic [2:0] page;
        logic [7:0] mask;
    } t_stim_row;

    localparam int N_DIRECTED = 25;

    // directed stimulus: typed points only for zero radius starts, none for ignored steps
    t_stim_row directed_rows [0:N_DIRECTED-1] = '{
        '{cpg_pkg::ACT_STEP,  8'h5A, 8'hA5, 7'd9,   NO_POINTS, 7'd0, 6'd0, 3'd0, 8'h00},
        '{cpg_pkg::ACT_START, 8'd10, 8'd20, 7'd0,   CENTRE_X4, 7'd10, 6'd20, 3'd2, 8'h08},
        '{cpg_pkg::ACT_STEP,  8'h00, 8'h00, 7'd0,   NO_POINTS, 7'd0, 6'd0, 3'd0, 8'h00},
        '{cpg_pkg::ACT_START, 8'hFF, 8'hFF, 7'd0,   CENTRE_X4, 7'd127, 6'd63, 3'd7, 8'h01},
        '{cpg_pkg::ACT_START, 8'h00, 8'h00, 7'd0,   CENTRE_X4, 7'd0, 6'd0, 3'd0, 8'h80},
        '{cpg_pkg::ACT_START, 8'd64, 8'd32, 7'd3,   BY_MODEL,  7'd0, 6'd0, 3'd0, 8'h00},
        '{cpg_pkg::ACT_STEP,  8'hFF, 8'hFF, 7'd127, BY_MODEL,  7'd0, 6'd0, 3'd0, 8'h00},
        '{cpg_pkg::ACT_STEP,  8'h00, 8'h00, 7'd0,   BY_MODEL,  7'd0, 6'd0, 3'd0, 8'h00},
        '{cpg_pkg::ACT_STEP,  8'h33, 8'hCC, 7'd21,  BY_MODEL,  7'd0, 6'd0, 3'd0, 8'h00},
        '{cpg_pkg::ACT_STEP,  8'h00, 8'h00, 7'd0,   BY_MODEL,  7'd0, 6'd0, 3'd0, 8'h00},
        '{cpg_pkg::ACT_START, 8'h00, 8'h00, 7'd127, BY_MODEL,  7'd0, 6'd0, 3'd0, 8'h00},
        '{cpg_pkg::ACT_STEP,  8'h00, 8'h00, 7'd0,   BY_MODEL,  7'd0, 6'd0, 3'd0, 8'h00},
        '{cpg_pkg::ACT_STEP,  8'h00, 8'h00, 7'd0,   BY_MODEL,  7'd0, 6'd0, 3'd0, 8'h00},
        '{cpg_pkg::ACT_STEP,  8'h00, 8'h00, 7'd0,   BY_MODEL,  7'd0, 6'd0, 3'd0, 8'h00},
        '{cpg_pkg::ACT_START, 8'hFF, 8'hFF, 7'd127, BY_MODEL,  7'd0, 6'd0, 3'd0, 8'h00},
        '{cpg_pkg::ACT_STEP,  8'h00, 8'h00, 7'd0,   BY_MODEL,  7'd0, 6'd0, 3'd0, 8'h00},
        '{cpg_pkg::ACT_STEP,  8'h00, 8'h00, 7'd0,   BY_MODEL,  7'd0, 6'd0, 3'd0, 8'h00},
        '{cpg_pkg::ACT_START, 8'd127, 8'd63, 7'd64, BY_MODEL,  7'd0, 6'd0, 3'd0, 8'h00},
        '{cpg_pkg::ACT_STEP,  8'h00, 8'h00, 7'd0,   BY_MODEL,  7'd0, 6'd0, 3'd0, 8'h00},
        '{cpg_pkg::ACT_START, 8'd100, 8'd40, 7'd1,  BY_MODEL,  7'd0, 6'd0, 3'd0, 8'h00},
        '{cpg_pkg::ACT_STEP,  8'h00, 8'h00, 7'd0,   BY_MODEL,  7'd0, 6'd0, 3'd0, 8'h00},
        '{cpg_pkg::ACT_STEP,  8'h00, 8'h00, 7'd0,   BY_MODEL,  7'd0, 6'd0, 3'd0, 8'h00},
        '{cpg_pkg::ACT_STEP,  8'h00, 8'h00, 7'd0,   BY_MODEL,  7'd0, 6'd0, 3'd0, 8'h00},
        '{cpg_pkg::ACT_START, 8'd200, 8'd70, 7'd2,  BY_MODEL,  7'd0, 6'd0, 3'd0, 8'h00},
        '{cpg_pkg::ACT_STEP,  8'h00, 8'h00, 7'd0,   BY_MODEL,  7'd0, 6'd0, 3'd0, 8'h00}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    cpg_in_if  in_ch ();
    cpg_out_if out_ch ();

    circle_pixel_generator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // points still owed by the block, oldest first
    t_pixel pending_points [$];
    int     mismatches = 0;

    // rasterizer state as the bench sees it
    logic signed [8:0]  cur_xx   = '0;
    logic signed [8:0]  cur_yy   = '0;
    logic signed [11:0] cur_err  = '0;
    logic [7:0]         ctr_x    = '0;
    logic [7:0]         ctr_y    = '0;
    bit                 circle_on = 1'b0;

    // handshakes between stimulus and the output stall process
    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;
    bit calm      = 1'b0;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // one iteration of the midpoint scheme: four quadrant points, then the cursor update
    task automatic plot_iteration(input logic act, input logic [7:0] x, input logic [7:0] y,
                                  input logic [6:0] rad, input bit queue_it);
        logic signed [8:0]  nx;
        logic signed [8:0]  ny;
        logic signed [11:0] ne;
        bit                 fin;
        int                 xx;
        int                 yy;
        int                 px [4];
        int                 py [4];
        int                 col;
        int                 rw;
        t_pixel             p;
        if (act == cpg_pkg::ACT_START) begin
            ctr_x     = x;
            ctr_y     = y;
            cur_xx    = 9'(-int'(rad));
            cur_yy    = '0;
            cur_err   = 12'(2 - 2 * int'(rad));
            circle_on = 1'b1;
        end else if (!circle_on) begin
            return;
        end
        nx = cur_xx;
        ny = cur_yy;
        ne = cur_err;
        if (int'(ne) > int'(nx)) begin
            nx = 9'(int'(nx) + 1);
            ne = 12'(int'(ne) + 2 * int'(nx) + 1);
        end
        if (int'(ne) <= int'(ny)) begin
            ny = 9'(int'(ny) + 1);
            ne = 12'(int'(ne) + 2 * int'(ny) + 1);
        end
        fin = !nx[8];
        // points come from the cursor before the update
        xx = int'(cur_xx);
        yy = int'(cur_yy);
        px = '{int'(ctr_x) - xx, int'(ctr_x) - yy, int'(ctr_x) + xx, int'(ctr_x) + yy};
        py = '{int'(ctr_y) + yy, int'(ctr_y) - xx, int'(ctr_y) - yy, int'(ctr_y) + xx};
        for (int k = 0; k < 4; k++) begin
            col = px[k] & 255;
            rw  = py[k] & 255;
            if (col > int'(cpg_pkg::DEF_WIDTH) - 1)  col = int'(cpg_pkg::DEF_WIDTH) - 1;
            if (rw > int'(cpg_pkg::DEF_HEIGHT) - 1)  rw  = int'(cpg_pkg::DEF_HEIGHT) - 1;
            p.column = 7'(col);
            p.row    = 6'(rw);
            p.page   = 3'(rw >> 3);
            p.mask   = 8'(cpg_pkg::MASK_TOP >> (rw & 7));
            p.last   = (k == 3);
            p.done   = fin;
            if (queue_it) pending_points.push_back(p);
        end
        cur_xx  = nx;
        cur_yy  = ny;
        cur_err = ne;
        if (fin) circle_on = 1'b0;
    endtask

    // offer one input transaction, wait for it to be taken, then update the prediction
    task automatic send_item(input logic act, input logic [7:0] x, input logic [7:0] y,
                             input logic [6:0] rad, input bit queue_it);
        if (!calm && !(hold_req && !hold_done) && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.action   <= act;
        in_ch.center_x <= x;
        in_ch.center_y <= y;
        in_ch.radius   <= rad;
        do @(posedge i_clk); while (!in_ch.ready);
        plot_iteration(act, x, y, rad, queue_it);
    endtask

    // output stall pattern: random bursts, one long hold, none at the end
    initial begin
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // point checker
    always @(posedge i_clk) begin
        t_pixel got;
        t_pixel want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.pixel_column, out_ch.pixel_row, out_ch.page_index,
                    out_ch.bit_mask, out_ch.last_of_step, out_ch.circle_done};
            if (pending_points.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"%0t: unexpected point col=%0d row=%0d page=%0d mask=%h ",
                              "last=%b done=%b"},
                             $realtime, got.column, got.row, got.page, got.mask, got.last,
                             got.done);
            end else begin
                want = pending_points.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"%0t: point mismatch exp col=%0d row=%0d page=%0d mask=%h ",
                                  "last=%b done=%b / got col=%0d row=%0d page=%0d mask=%h ",
                                  "last=%b done=%b"}, $realtime,
                                 want.column, want.row, want.page, want.mask, want.last,
                                 want.done, got.column, got.row, got.page, got.mask,
                                 got.last, got.done);
                end
            end
        end
    end

    // stimulus and end of run
    initial begin
        t_stim_row  sr;
        t_pixel     p;
        int         items_sent;
        int         steps;
        int         step_cap;
        int         roll;
        logic [7:0] x;
        logic [7:0] y;
        logic [6:0] rad;
        i_rst_n        <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.action   <= cpg_pkg::ACT_START;
        in_ch.center_x <= '0;
        in_ch.center_y <= '0;
        in_ch.radius   <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows
        for (int i = 0; i < N_DIRECTED; i++) begin
            sr = directed_rows[i];
            send_item(sr.act, sr.x, sr.y, sr.rad, sr.chk == BY_MODEL);
            if (sr.chk == CENTRE_X4) begin
                for (int k = 0; k < 4; k++) begin
                    p = '{sr.column, sr.row, sr.page, sr.mask, k == 3, 1'b1};
                    pending_points.push_back(p);
                end
            end
        end

        // random circles: mostly complete, some abandoned, with stray steps between them
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent >= 20) hold_req = 1'b1;
            if (items_sent >= RANDOM_ITEMS - 25) calm = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 75)      rad = 7'($urandom_range(0, 10));
            else if (roll < 93) rad = 7'($urandom_range(11, 40));
            else                rad = 7'($urandom_range(41, 127));
            if ($urandom_range(0, 1) == 1) begin
                x = 8'($urandom_range(0, 127));
                y = 8'($urandom_range(0, 63));
            end else begin
                x = 8'($urandom);
                y = 8'($urandom);
            end
            send_item(cpg_pkg::ACT_START, x, y, rad, 1'b1);
            items_sent++;
            step_cap = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4) : 40;
            steps = 0;
            while (circle_on && steps < step_cap && items_sent < RANDOM_ITEMS) begin
                send_item(cpg_pkg::ACT_STEP, 8'($urandom), 8'($urandom), 7'($urandom), 1'b1);
                steps++;
                items_sent++;
            end
            if (!circle_on && items_sent < RANDOM_ITEMS && $urandom_range(0, 4) == 0) begin
                send_item(cpg_pkg::ACT_STEP, 8'($urandom), 8'($urandom), 7'($urandom), 1'b1);
                items_sent++;
            end
        end
        in_ch.valid <= 1'b0;

        // drain and let the pipeline settle
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending_points.size() == 0)
            $display("** circle_pixel_generator: PASSED **");
        else
            $display("** circle_pixel_generator: FAILED **");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("** circle_pixel_generator: FAILED **");
        $finish;
    end

endmodule
